// ----- sv/swm_pkg.sv -----
// ----------------------------------------------------------------------------
// Sliding window median package
// Shared types and constants for the sorted cell row and its top level.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

    // Width of the window size register.
    localparam int unsigned WSIZE_W = 7;

    // Window size after reset.
    localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd3;

    // Control that the top level broadcasts to every cell in the row.
    typedef struct packed {
        logic load;     // an input beat is taken in this cycle
        logic full;     // the new sample completes the window
    } t_cell_ctl;

endpackage : swm_pkg

`default_nettype wire

// ----- sv/swm_cell.sv -----
// ----------------------------------------------------------------------------
// Sliding window median cell
// One slot of the sorted row: holds a sample and its age, inserts the new
// sample by shifting right and drops the oldest sample by shifting left.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_cell
    import swm_pkg::*;
#(
    parameter int unsigned DATA_W = 32,
    parameter int unsigned AGE_W  = 6,
    parameter bit          FIRST  = 1'b0
) (
    input  wire                      i_clk,
    input  wire t_cell_ctl           i_ctl,
    input  wire                      i_held,
    input  wire                      i_ins_valid,
    input  wire signed [DATA_W-1:0]  i_sample,
    input  wire        [AGE_W-1:0]   i_oldest_age,
    input  wire signed [DATA_W-1:0]  i_left_value,
    input  wire        [AGE_W-1:0]   i_left_age,
    input  wire                      i_left_gt,
    input  wire signed [DATA_W-1:0]  i_right_ins_value,
    input  wire        [AGE_W-1:0]   i_right_ins_age,
    input  wire                      i_del_in,
    output logic                     o_gt,
    output logic signed [DATA_W-1:0] o_ins_value,
    output logic        [AGE_W-1:0]  o_ins_age,
    output logic                     o_del_out,
    output logic signed [DATA_W-1:0] o_value,
    output logic        [AGE_W-1:0]  o_age
);

    logic signed [DATA_W-1:0] r_value;
    logic        [AGE_W-1:0]  r_age;
    logic                     del_here;

    // The stored entry is handed to the right neighbor.
    assign o_value = r_value;
    assign o_age   = r_age;

    // An empty slot counts as larger than any sample.
    assign o_gt = !i_held || (r_value > i_sample);

    // Insertion: the first slot above the sample takes it, the rest shift right.
    always_comb begin
        if (o_gt) begin
            if (FIRST || !i_left_gt) begin
                o_ins_value = i_sample;
                o_ins_age   = '0;
            end else begin
                o_ins_value = i_left_value;
                o_ins_age   = i_left_age + AGE_W'(1);
            end
        end else begin
            o_ins_value = r_value;
            o_ins_age   = r_age + AGE_W'(1);
        end
    end

    // Removal: the oldest entry is marked and the mark ripples to the right.
    assign del_here  = i_ctl.full && i_ins_valid && (o_ins_age == i_oldest_age);
    assign o_del_out = i_del_in || del_here;

    // Slots at or above the removed entry take their right neighbor.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            if (o_del_out) begin
                r_value <= i_right_ins_value;
                r_age   <= i_right_ins_age;
            end else begin
                r_value <= o_ins_value;
                r_age   <= o_ins_age;
            end
        end
    end

endmodule : swm_cell

`default_nettype wire

// ----- sv/sliding_window_median.sv -----
// ----------------------------------------------------------------------------
// Sliding window median
// Keeps the last samples in a sorted row of cells and emits the (lower)
// median of the window for every sample once the window is full.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                   Data
//  --------  ---------  --------------------------  ------------------------
//  input     in         i_valid / o_ready           i_sample, i_restart
//  output    out        o_valid / i_ready           o_median
//  config    in         i_window_size_we (no wait)  i_window_size
//
//  One input beat per cycle when not stalled; its median comes the next cycle.
//  Insertion, median pick and removal of the oldest sample all happen in the
//  cell row in the cycle the beat is taken; the output register sets latency.
//  o_ready drops only while a median waits on a stalled output.
//  Reset clears the held count and loads a window size of three; no clearing
//  pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_median
    import swm_pkg::*;
#(
    parameter int unsigned MAX_WINDOW  = 64,
    parameter int unsigned SAMPLE_BITS = 32
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_ready,
    input  wire signed [SAMPLE_BITS-1:0]  i_sample,
    input  wire                           i_restart,
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_median,
    input  wire                           i_window_size_we,
    input  wire        [WSIZE_W-1:0]      i_window_size
);

    localparam int unsigned AGE_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);

    // Effective window size: zero reads as one, large values saturate.
    function automatic logic [CNT_W-1:0] eff_size(input logic [WSIZE_W-1:0] ws);
        logic [CNT_W-1:0] k;
        if (ws == '0) begin
            k = CNT_W'(1);
        end else if (32'(ws) > MAX_WINDOW) begin
            k = CNT_W'(MAX_WINDOW);
        end else begin
            k = CNT_W'(ws);
        end
        return k;
    endfunction

    logic [CNT_W-1:0] r_k;
    logic [CNT_W-1:0] n_k;
    logic [AGE_W-1:0] r_oldest;
    logic [AGE_W-1:0] n_oldest;
    logic [AGE_W-1:0] r_mid;
    logic [AGE_W-1:0] n_mid;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] n_fill;
    logic [CNT_W-1:0] held_cnt;
    logic             r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_median;
    logic             accept;
    t_cell_ctl        ctl;

    logic                          gt       [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] ins_val  [MAX_WINDOW];
    logic        [AGE_W-1:0]       ins_age  [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] cell_val [MAX_WINDOW];
    logic        [AGE_W-1:0]       cell_age [MAX_WINDOW];
    logic                          del      [MAX_WINDOW+1];

    // Window geometry follows the register and is fixed between writes.
    assign n_k      = eff_size(i_window_size);
    assign n_oldest = AGE_W'(n_k - CNT_W'(1));
    assign n_mid    = AGE_W'((n_k - CNT_W'(1)) >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k      <= eff_size(WSIZE_RESET);
            r_oldest <= AGE_W'(eff_size(WSIZE_RESET) - CNT_W'(1));
            r_mid    <= AGE_W'((eff_size(WSIZE_RESET) - CNT_W'(1)) >> 1);
        end else if (i_window_size_we) begin
            r_k      <= n_k;
            r_oldest <= n_oldest;
            r_mid    <= n_mid;
        end
    end

    // Handshake: a new beat is taken unless a median waits on a stalled output.
    assign o_ready  = !r_out_valid || i_ready;
    assign accept   = i_valid && o_ready;
    assign held_cnt = i_restart ? '0 : r_fill;
    assign ctl.load = accept;
    assign ctl.full = ((held_cnt + CNT_W'(1)) == r_k);
    assign n_fill   = ctl.full ? held_cnt : held_cnt + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_window_size_we) begin
            r_fill <= '0;
        end else if (accept) begin
            r_fill <= n_fill;
        end
    end

    // Sorted cell row, smallest sample in cell zero.
    assign del[0] = 1'b0;

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        logic signed [SAMPLE_BITS-1:0] left_val;
        logic        [AGE_W-1:0]       left_age;
        logic                          left_gt;
        logic signed [SAMPLE_BITS-1:0] right_val;
        logic        [AGE_W-1:0]       right_age;

        if (g == 0) begin : g_left_edge
            assign left_val = '0;
            assign left_age = '0;
            assign left_gt  = 1'b0;
        end else begin : g_left_cell
            assign left_val = cell_val[g-1];
            assign left_age = cell_age[g-1];
            assign left_gt  = gt[g-1];
        end

        if (g == MAX_WINDOW - 1) begin : g_right_edge
            assign right_val = '0;
            assign right_age = '0;
        end else begin : g_right_cell
            assign right_val = ins_val[g+1];
            assign right_age = ins_age[g+1];
        end

        swm_cell #(
            .DATA_W (SAMPLE_BITS),
            .AGE_W  (AGE_W),
            .FIRST  (g == 0)
        ) u_cell (
            .i_clk             (i_clk),
            .i_ctl             (ctl),
            .i_held            (CNT_W'(g) < held_cnt),
            .i_ins_valid       (CNT_W'(g) <= held_cnt),
            .i_sample          (i_sample),
            .i_oldest_age      (r_oldest),
            .i_left_value      (left_val),
            .i_left_age        (left_age),
            .i_left_gt         (left_gt),
            .i_right_ins_value (right_val),
            .i_right_ins_age   (right_age),
            .i_del_in          (del[g]),
            .o_gt              (gt[g]),
            .o_ins_value       (ins_val[g]),
            .o_ins_age         (ins_age[g]),
            .o_del_out         (del[g+1]),
            .o_value           (cell_val[g]),
            .o_age             (cell_age[g])
        );
    end

    // Output register: the median is the middle slot after insertion.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= ctl.full;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && ctl.full) begin
            r_median <= ins_val[r_mid];
        end
    end

    assign o_valid  = r_out_valid;
    assign o_median = r_median;

    // The held count always stays below the window size.
    a_fill_below_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < r_k)
        else $error("held count reached the window size");

    // A beat that completes the window yields a median in the next cycle.
    a_full_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && ctl.full |=> o_valid)
        else $error("full window produced no median");

    // A register write empties the window.
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_window_size_we |=> r_fill == '0)
        else $error("window not emptied by register write");

    // Input stalls only behind a waiting median.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled without a waiting median");

endmodule : sliding_window_median

`default_nettype wire
